FILE: hdl/assert_macros.svh
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, disabled while reset is asserted.
`define MCRQS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scheduler assertion failed");

// Clocked check that also holds while reset is asserted.
`define MCRQS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("scheduler assertion failed during reset");

`else

`define MCRQS_ASSERT(lbl, prop)
`define MCRQS_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: hdl/mcrqs_pkg.sv
// Types and codes shared by the ready-queue scheduler modules.
`timescale 1ns / 1ps

package mcrqs_pkg;

    // event codes (yield and terminate take the plain dispatch path)
    localparam logic [2:0] OP_WAKE    = 3'd0;
    localparam logic [2:0] OP_PREEMPT = 3'd1;
    localparam logic [2:0] OP_IDLE    = 3'd4;

    // result actions
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_RUN      = 2'd1;
    localparam logic [1:0] ACT_RUN_IDLE = 2'd2;
    localparam logic [1:0] ACT_PREEMPT  = 2'd3;

    // scheduling mode; every other code queues in arrival order
    localparam logic [1:0] MODE_SRTF = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_SLICE  = 2'd1;
    localparam logic [1:0] CFG_ACTIVE = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  cpu;
        logic [15:0] proc_id;
        logic [15:0] time_left;
    } evt_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  target_cpu;
        logic [15:0] run_id;
        logic [15:0] slice_out;
        logic        queue_overflow;
    } res_t;

    // one ready queue entry
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] tm;
    } qent_t;

    typedef struct packed {
        logic        we;
        logic        busy;
        logic [15:0] id;
        logic [15:0] tm;
    } cpu_wr_t;

    typedef struct packed {
        logic        busy;
        logic [15:0] id;
        logic [15:0] tm;
    } cpu_rd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SCAN,
        S_INS_TAIL,
        S_CPU_SCAN,
        S_CPU_CHK,
        S_DISP,
        S_POP,
        S_DONE
    } state_t;

endpackage

FILE: hdl/mcrqs_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mcrqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/mcrqs_cpu_tab.sv
// Per-CPU running table: busy flags, running id and reported time.
`timescale 1ns / 1ps

module mcrqs_cpu_tab #(
    parameter int NUM_CPUS = 4,
    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CPU_W-1:0]    idx,
    input  mcrqs_pkg::cpu_wr_t  wr,
    output mcrqs_pkg::cpu_rd_t  rd
);

    logic [NUM_CPUS-1:0] busy_reg;
    logic [15:0]         id_reg [NUM_CPUS];
    logic [15:0]         tm_reg [NUM_CPUS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (wr.we)
        begin
            busy_reg[idx] <= wr.busy;
        end
    end

    // id/time only matter while busy
    always_ff @(posedge clk)
    begin
        if (wr.we && wr.busy)
        begin
            id_reg[idx] <= wr.id;
            tm_reg[idx] <= wr.tm;
        end
    end

    assign rd.busy = busy_reg[idx];
    assign rd.id   = id_reg[idx];
    assign rd.tm   = tm_reg[idx];

endmodule

FILE: hdl/multi_cpu_ready_queue_scheduler_top.sv
// Top level of the multi-CPU ready-queue scheduler.
`timescale 1ns / 1ps

// Ready-queue scheduler for up to NUM_CPUS CPUs. Each event item (wake-up,
// preempt, yield, terminate, idle) yields exactly one result item. The queue
// is a circular buffer in a single RAM (QUEUE_DEPTH entries of id and time)
// walked by a small sequencer around one shared 16-bit comparator; the CPU
// table sits in flops. Only one event is in flight: evt_stall is high from
// acceptance until its result is loaded into the output register, and a
// result waiting on res_stall does not block the next event. An ignored
// event or a wake-up dropped on a full queue goes straight to the result;
// a FIFO/round-robin wake-up writes the queue tail; a dispatch pops the
// queue head, or reports idle on an empty queue; a preempt that requeues
// the running process writes the tail before its dispatch. SRTF insertion
// into a non-empty queue walks the queued entries in order, one RAM read
// per cycle, for the ordered insert; SRTF wake-up then scans the CPUs up
// to and including the first idle one, plus a final compare when every
// scanned CPU is busy. The sequencer returns to idle before the next event
// is taken. No memory clearing pass after reset. Config writes (sched_mode,
// slice_length, active_cpus) are registered.

`include "assert_macros.svh"

module multi_cpu_ready_queue_scheduler_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_CPUS    = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    // event channel
    input  logic              evt_valid,
    output logic              evt_stall,
    input  mcrqs_pkg::evt_t   evt,
    // result channel
    output logic              res_valid,
    input  logic              res_stall,
    output mcrqs_pkg::res_t   res,
    // configuration
    input  logic              cfg_en,
    input  logic [1:0]        cfg_addr,
    input  logic [15:0]       cfg_data
);

    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam logic [QW:0]   DEPTH_C = (QW + 1)'(QUEUE_DEPTH);
    localparam logic [QW-1:0] HEAD_MAX = QW'(QUEUE_DEPTH - 1);

    // configuration
    logic [1:0]  mode_reg, mode_next;
    logic [15:0] slice_reg, slice_next;
    logic [2:0]  active_reg, active_next;

    // sequencer
    mcrqs_pkg::state_t state_reg, state_next;
    mcrqs_pkg::evt_t   evt_reg, evt_next;
    logic [CPU_W-1:0]  cpu_idx_reg, cpu_idx_next;

    // queue bookkeeping
    logic [QW-1:0]     head_reg, head_next;
    logic [QW:0]       count_reg, count_next;
    logic [QW:0]       idx_reg, idx_next;
    logic              found_reg, found_next;
    mcrqs_pkg::qent_t  carry_reg, carry_next;
    mcrqs_pkg::qent_t  ins_reg, ins_next;

    // SRTF CPU scan
    logic [15:0]       longest_reg, longest_next;
    logic [CPU_W-1:0]  pick_reg, pick_next;

    // result build-up and output register
    logic [1:0]        act_reg, act_next;
    logic [1:0]        tgt_reg, tgt_next;
    logic [15:0]       rid_reg, rid_next;
    logic              ovf_reg, ovf_next;
    mcrqs_pkg::res_t   res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    // RAM ports
    logic              ram_we;
    logic [QW:0]       ram_wk;
    logic [QW:0]       ram_rk;
    mcrqs_pkg::qent_t  ram_wdata;
    logic [$bits(mcrqs_pkg::qent_t)-1:0] ram_rdata;
    mcrqs_pkg::qent_t  rd_q;

    // CPU table ports
    mcrqs_pkg::cpu_wr_t cpu_wr;
    mcrqs_pkg::cpu_rd_t cpu_rd;

    // shared comparator
    logic [15:0] cmp_a, cmp_b;
    logic        cmp_lt;

    logic              q_full, q_empty, q_last, srtf, cpu_ok, ins_now;
    logic              scan_last, res_load;
    logic [4:0]        scan_n;
    mcrqs_pkg::state_t ins_start;

    // logical queue slot -> RAM address
    function automatic logic [QW-1:0] q_phys(input logic [QW-1:0] h, input logic [QW:0] k);
        logic [QW:0] s;
        s = {1'b0, h} + k;
        if (s >= DEPTH_C)
        begin
            s = s - DEPTH_C;
        end
        return s[QW-1:0];
    endfunction

    mcrqs_ram #(
        .WIDTH ($bits(mcrqs_pkg::qent_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_phys(head_reg, ram_wk)),
        .wdata (ram_wdata),
        .raddr (q_phys(head_reg, ram_rk)),
        .rdata (ram_rdata)
    );

    mcrqs_cpu_tab #(
        .NUM_CPUS (NUM_CPUS)
    ) u_cpu_tab (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (cpu_idx_reg),
        .wr    (cpu_wr),
        .rd    (cpu_rd)
    );

    assign rd_q      = mcrqs_pkg::qent_t'(ram_rdata);
    assign q_full    = (count_reg == DEPTH_C);
    assign q_empty   = (count_reg == '0);
    assign q_last    = (idx_reg == count_reg - (QW + 1)'(1));
    assign srtf      = (mode_reg == mcrqs_pkg::MODE_SRTF);
    assign cpu_ok    = (int'(evt_reg.cpu) < NUM_CPUS);
    assign scan_n    = (5'(active_reg) > 5'(NUM_CPUS)) ? 5'(NUM_CPUS) : 5'(active_reg);
    assign scan_last = ((5'(cpu_idx_reg) + 5'd1) == scan_n);
    assign res_load  = !res_valid_reg || !res_stall;
    assign ins_start = (srtf && !q_empty) ? mcrqs_pkg::S_INS_SCAN : mcrqs_pkg::S_INS_TAIL;

    // Comparator operands. Slot 0 is taken only on a strictly shorter time;
    // later slots on the first time at least as long as the new one.
    always_comb
    begin
        cmp_a = '0;
        cmp_b = '0;
        case (state_reg)
            mcrqs_pkg::S_INS_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    cmp_a = ins_reg.tm;
                    cmp_b = rd_q.tm;
                end
                else
                begin
                    cmp_a = rd_q.tm;
                    cmp_b = ins_reg.tm;
                end
            end
            mcrqs_pkg::S_CPU_SCAN:
            begin
                cmp_a = longest_reg;
                cmp_b = cpu_rd.tm;
            end
            mcrqs_pkg::S_CPU_CHK:
            begin
                cmp_a = ins_reg.tm;
                cmp_b = longest_reg;
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_lt  = (cmp_a < cmp_b);
    assign ins_now = !found_reg && ((idx_reg == '0) ? cmp_lt : !cmp_lt);

    // configuration decode
    always_comb
    begin
        mode_next   = mode_reg;
        slice_next  = slice_reg;
        active_next = active_reg;
        if (cfg_en)
        begin
            unique case (cfg_addr)
                mcrqs_pkg::CFG_MODE:   mode_next   = cfg_data[1:0];
                mcrqs_pkg::CFG_SLICE:  slice_next  = cfg_data;
                mcrqs_pkg::CFG_ACTIVE: active_next = cfg_data[2:0];
                default:               ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcrqs_pkg::S_IDLE:
            begin
                if (evt_valid)
                begin
                    state_next = mcrqs_pkg::S_DECODE;
                end
            end
            mcrqs_pkg::S_DECODE:
            begin
                if (evt_reg.operation == mcrqs_pkg::OP_WAKE)
                begin
                    state_next = q_full ? mcrqs_pkg::S_DONE : ins_start;
                end
                else if (evt_reg.operation > mcrqs_pkg::OP_IDLE || !cpu_ok)
                begin
                    state_next = mcrqs_pkg::S_DONE;
                end
                else if (evt_reg.operation == mcrqs_pkg::OP_PREEMPT && cpu_rd.busy && !q_full)
                begin
                    state_next = ins_start;
                end
                else
                begin
                    state_next = mcrqs_pkg::S_DISP;
                end
            end
            mcrqs_pkg::S_INS_SCAN:
            begin
                if (q_last)
                begin
                    state_next = mcrqs_pkg::S_INS_TAIL;
                end
            end
            mcrqs_pkg::S_INS_TAIL:
            begin
                if (evt_reg.operation == mcrqs_pkg::OP_WAKE)
                begin
                    state_next = (srtf && scan_n != '0) ? mcrqs_pkg::S_CPU_SCAN
                                                        : mcrqs_pkg::S_DONE;
                end
                else
                begin
                    state_next = mcrqs_pkg::S_DISP;
                end
            end
            mcrqs_pkg::S_CPU_SCAN:
            begin
                if (!cpu_rd.busy)
                begin
                    state_next = mcrqs_pkg::S_DONE;
                end
                else if (scan_last)
                begin
                    state_next = mcrqs_pkg::S_CPU_CHK;
                end
            end
            mcrqs_pkg::S_CPU_CHK:
            begin
                state_next = mcrqs_pkg::S_DONE;
            end
            mcrqs_pkg::S_DISP:
            begin
                state_next = q_empty ? mcrqs_pkg::S_DONE : mcrqs_pkg::S_POP;
            end
            mcrqs_pkg::S_POP:
            begin
                state_next = mcrqs_pkg::S_DONE;
            end
            mcrqs_pkg::S_DONE:
            begin
                if (res_load)
                begin
                    state_next = mcrqs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mcrqs_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        evt_next       = evt_reg;
        cpu_idx_next   = cpu_idx_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        carry_next     = carry_reg;
        ins_next       = ins_reg;
        longest_next   = longest_reg;
        pick_next      = pick_reg;
        act_next       = act_reg;
        tgt_next       = tgt_reg;
        rid_next       = rid_reg;
        ovf_next       = ovf_reg;
        res_next       = res_reg;
        res_valid_next = res_stall ? res_valid_reg : 1'b0;
        ram_we         = 1'b0;
        ram_wk         = '0;
        ram_wdata      = ins_reg;
        ram_rk         = '0;
        cpu_wr         = '0;

        unique case (state_reg)
            mcrqs_pkg::S_IDLE:
            begin
                if (evt_valid)
                begin
                    evt_next     = evt;
                    cpu_idx_next = CPU_W'(evt.cpu);
                end
            end
            mcrqs_pkg::S_DECODE:
            begin
                act_next   = mcrqs_pkg::ACT_NONE;
                tgt_next   = '0;
                rid_next   = '0;
                ovf_next   = 1'b0;
                idx_next   = '0;
                found_next = 1'b0;
                if (evt_reg.operation == mcrqs_pkg::OP_WAKE)
                begin
                    ovf_next = q_full;
                    ins_next = '{id: evt_reg.proc_id, tm: evt_reg.time_left};
                end
                else if (evt_reg.operation == mcrqs_pkg::OP_PREEMPT && cpu_ok && cpu_rd.busy)
                begin
                    // running entry goes back with its reported time
                    ovf_next = q_full;
                    ins_next = '{id: cpu_rd.id, tm: evt_reg.time_left};
                end
            end
            mcrqs_pkg::S_INS_SCAN:
            begin
                // read one slot ahead while rewriting the current one
                ram_rk   = idx_reg + (QW + 1)'(1);
                ram_wk   = idx_reg;
                idx_next = idx_reg + (QW + 1)'(1);
                if (ins_now)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ins_reg;
                    carry_next = rd_q;
                    found_next = 1'b1;
                end
                else if (found_reg)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = carry_reg;
                    carry_next = rd_q;
                end
            end
            mcrqs_pkg::S_INS_TAIL:
            begin
                ram_we     = 1'b1;
                ram_wk     = count_reg;
                ram_wdata  = found_reg ? carry_reg : ins_reg;
                count_next = count_reg + (QW + 1)'(1);
                if (evt_reg.operation == mcrqs_pkg::OP_WAKE)
                begin
                    cpu_idx_next = '0;
                    longest_next = '0;
                    pick_next    = '0;
                end
            end
            mcrqs_pkg::S_CPU_SCAN:
            begin
                if (cpu_rd.busy)
                begin
                    if (cmp_lt)
                    begin
                        longest_next = cpu_rd.tm;
                        pick_next    = cpu_idx_reg;
                    end
                    if (!scan_last)
                    begin
                        cpu_idx_next = cpu_idx_reg + CPU_W'(1);
                    end
                end
            end
            mcrqs_pkg::S_CPU_CHK:
            begin
                if (cmp_lt)
                begin
                    act_next = mcrqs_pkg::ACT_PREEMPT;
                    tgt_next = 2'(pick_reg);
                end
            end
            mcrqs_pkg::S_DISP:
            begin
                tgt_next = evt_reg.cpu;
                if (q_empty)
                begin
                    act_next    = mcrqs_pkg::ACT_RUN_IDLE;
                    cpu_wr.we   = 1'b1;
                    cpu_wr.busy = 1'b0;
                end
            end
            mcrqs_pkg::S_POP:
            begin
                act_next    = mcrqs_pkg::ACT_RUN;
                rid_next    = rd_q.id;
                cpu_wr.we   = 1'b1;
                cpu_wr.busy = 1'b1;
                cpu_wr.id   = rd_q.id;
                cpu_wr.tm   = rd_q.tm;
                head_next   = (head_reg == HEAD_MAX) ? '0 : head_reg + QW'(1);
                count_next  = count_reg - (QW + 1)'(1);
            end
            mcrqs_pkg::S_DONE:
            begin
                if (res_load)
                begin
                    res_next.action         = act_reg;
                    res_next.target_cpu     = tgt_reg;
                    res_next.run_id         = rid_reg;
                    res_next.slice_out      = (act_reg == mcrqs_pkg::ACT_RUN ||
                                               act_reg == mcrqs_pkg::ACT_RUN_IDLE)
                                              ? slice_reg : 16'd0;
                    res_next.queue_overflow = ovf_reg;
                    res_valid_next          = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcrqs_pkg::S_IDLE;
            mode_reg      <= '0;
            slice_reg     <= '0;
            active_reg    <= 3'd1;
            head_reg      <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            slice_reg     <= slice_next;
            active_reg    <= active_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_reg     <= evt_next;
        cpu_idx_reg <= cpu_idx_next;
        idx_reg     <= idx_next;
        carry_reg   <= carry_next;
        ins_reg     <= ins_next;
        longest_reg <= longest_next;
        pick_reg    <= pick_next;
        act_reg     <= act_next;
        tgt_reg     <= tgt_next;
        rid_reg     <= rid_next;
        ovf_reg     <= ovf_next;
        res_reg     <= res_next;
    end

    assign evt_stall = (state_reg != mcrqs_pkg::S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // queue occupancy never passes the RAM depth
    `MCRQS_ASSERT(a_count_bound, count_reg <= DEPTH_C)
    // occupancy moves only on a tail write or a pop
    `MCRQS_ASSERT(a_count_move, (count_reg != $past(count_reg)) |->
        ($past(state_reg) == mcrqs_pkg::S_INS_TAIL || $past(state_reg) == mcrqs_pkg::S_POP))
    // a new result appears only out of the completion state
    `MCRQS_ASSERT(a_res_from_done, $rose(res_valid_reg) |-> ($past(state_reg) == mcrqs_pkg::S_DONE))
    // an edge seen in reset leaves the sequencer idle with an empty queue and no valid result
    `MCRQS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=>
        (state_reg == mcrqs_pkg::S_IDLE && count_reg == '0 && !res_valid_reg))

endmodule
